// ===== rtl/integer_to_ascii_formatter_assert.svh =====
// assertion macros used by the formatter top level
`ifndef INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH

// condition holds in the same cycle
`define ITOA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("itoa assertion failed");

// condition holds in the following cycle
`define ITOA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("itoa assertion failed");

`endif

// ===== rtl/itoa_pkg.sv =====
// types and constants of the integer to ascii formatter
`timescale 1ns / 1ps

package itoa_pkg;

	// format codes
	localparam logic [1:0] FMT_UDEC = 2'd0;
	localparam logic [1:0] FMT_SDEC = 2'd1;
	localparam logic [1:0] FMT_HEX  = 2'd2;
	localparam logic [1:0] FMT_BIN  = 2'd3;

	// character codes
	localparam logic [6:0] CH_NUL   = 7'h00;
	localparam logic [6:0] CH_ZERO  = 7'h30;
	localparam logic [6:0] CH_MINUS = 7'h2D;

	// string lengths of the fixed formats
	localparam logic [5:0] HEX_DIGITS = 6'd8;
	localparam logic [5:0] BIN_DIGITS = 6'd32;

	// reciprocal of ten, product shifted right by RECIP_SHIFT
	localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
	localparam int          RECIP_SHIFT = 35;

	localparam logic [6:0] HEX_TABLE [16] = '{
		7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
		7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46
	};

	typedef struct packed {
		logic [31:0] value;
		logic [1:0]  req_type;
		logic        add_terminator;
	} req_t;

	typedef struct packed {
		logic [6:0] out_char;
		logic [5:0] char_index;
		logic       is_last;
	} rsp_t;

	// classified command passed from front to back
	typedef struct packed {
		logic [31:0] mag;
		logic [1:0]  fmt;
		logic        neg;
		logic        term;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUB,
		ST_EMIT
	} state_t;

	function automatic logic [6:0] hex_char(input logic [3:0] nib);
		return HEX_TABLE[nib];
	endfunction

endpackage

// ===== rtl/itoa_front.sv =====
// front end: classifies a request into sign and magnitude
`timescale 1ns / 1ps

module itoa_front (
	input  itoa_pkg::req_t req,
	output itoa_pkg::cmd_t cmd
);

	logic neg;

	// sign only matters for signed decimal
	assign neg = (req.req_type == itoa_pkg::FMT_SDEC) && req.value[31];

	// magnitude is the unsigned negation for negative values
	always_comb begin
		cmd.fmt  = req.req_type;
		cmd.neg  = neg;
		cmd.term = req.add_terminator;
		cmd.mag  = neg ? (32'd0 - req.value) : req.value;
	end

endmodule

// ===== rtl/itoa_fifo.sv =====
// short command queue between front and back
`timescale 1ns / 1ps

module itoa_fifo #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  itoa_pkg::cmd_t din,
	output logic           full,
	input  logic           pop,
	output logic           valid,
	output itoa_pkg::cmd_t dout
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	itoa_pkg::cmd_t mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push;
	logic           do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign valid   = (count_q != '0);
	assign do_push = push && !full;
	assign do_pop  = pop && valid;
	assign dout    = mem_q[rd_ptr_q];

	// storage write
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/itoa_back.sv =====
// back end: decimal digit extraction and character emission
`timescale 1ns / 1ps

module itoa_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  itoa_pkg::cmd_t cmd,
	output logic           cmd_take,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output itoa_pkg::rsp_t rsp
);

	localparam int DIGITS = 10;

	itoa_pkg::state_t state_q;
	itoa_pkg::state_t state_nxt;

	logic [31:0] mag_q;
	logic [63:0] prod_q;
	logic [31:0] sh_q;
	logic [1:0]  fmt_q;
	logic        neg_q;
	logic        term_q;
	logic [3:0]  ndig_q;
	logic [3:0]  digs_q [DIGITS];
	logic [5:0]  body_left_q;
	logic [5:0]  idx_q;
	logic        out_valid_q;
	itoa_pkg::rsp_t out_q;

	logic [28:0] quot;
	logic [31:0] quot10;
	logic [31:0] rem_w;
	logic [5:0]  body_dec;
	logic [3:0]  rd_idx;
	logic        is_dec;
	logic        emit;
	logic        last;
	logic [6:0]  ch;

	// quotient and remainder from the registered product
	assign quot   = prod_q[63:itoa_pkg::RECIP_SHIFT];
	assign quot10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
	assign rem_w  = mag_q - quot10;

	assign body_dec = body_left_q - 6'd1;
	assign rd_idx   = body_dec[3:0];
	assign is_dec   = (fmt_q == itoa_pkg::FMT_UDEC) || (fmt_q == itoa_pkg::FMT_SDEC);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			itoa_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					if (cmd.fmt inside {itoa_pkg::FMT_UDEC, itoa_pkg::FMT_SDEC}) begin
						state_nxt = itoa_pkg::ST_MUL;
					end else begin
						state_nxt = itoa_pkg::ST_EMIT;
					end
				end
			end
			itoa_pkg::ST_MUL: state_nxt = itoa_pkg::ST_SUB;
			itoa_pkg::ST_SUB: begin
				state_nxt = (quot == '0) ? itoa_pkg::ST_EMIT : itoa_pkg::ST_MUL;
			end
			itoa_pkg::ST_EMIT: begin
				if (emit && last) begin
					state_nxt = itoa_pkg::ST_IDLE;
				end
			end
			default: state_nxt = itoa_pkg::ST_IDLE;
		endcase
	end

	// control outputs and character select
	always_comb begin
		cmd_take = (state_q == itoa_pkg::ST_IDLE) && cmd_valid;
		emit     = (state_q == itoa_pkg::ST_EMIT) && (!out_valid_q || !rsp_stall);
		last     = (body_left_q == 6'd0) || ((body_left_q == 6'd1) && !term_q);
		if (body_left_q == 6'd0) begin
			ch = itoa_pkg::CH_NUL;
		end else begin
			case (fmt_q)
				itoa_pkg::FMT_HEX: ch = itoa_pkg::hex_char(sh_q[31:28]);
				itoa_pkg::FMT_BIN: ch = itoa_pkg::CH_ZERO | {6'd0, sh_q[31]};
				default: begin
					ch = neg_q ? itoa_pkg::CH_MINUS : (itoa_pkg::CH_ZERO | {3'd0, digs_q[rd_idx]});
				end
			endcase
		end
	end

	// sequencer state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= itoa_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			itoa_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					mag_q  <= cmd.mag;
					sh_q   <= cmd.mag;
					fmt_q  <= cmd.fmt;
					neg_q  <= cmd.neg;
					term_q <= cmd.term;
					ndig_q <= '0;
					idx_q  <= '0;
					case (cmd.fmt)
						itoa_pkg::FMT_HEX: body_left_q <= itoa_pkg::HEX_DIGITS;
						itoa_pkg::FMT_BIN: body_left_q <= itoa_pkg::BIN_DIGITS;
						default:           body_left_q <= '0;
					endcase
				end
			end
			itoa_pkg::ST_MUL: begin
				prod_q <= mag_q * itoa_pkg::RECIP_TEN;
			end
			itoa_pkg::ST_SUB: begin
				digs_q[ndig_q] <= rem_w[3:0];
				ndig_q         <= ndig_q + 4'd1;
				mag_q          <= {3'b000, quot};
				body_left_q    <= 6'({5'd0, neg_q} + {2'd0, ndig_q} + 6'd1);
			end
			itoa_pkg::ST_EMIT: begin
				if (emit) begin
					out_q.out_char   <= ch;
					out_q.char_index <= idx_q;
					out_q.is_last    <= last;
					idx_q            <= idx_q + 6'd1;
					if (body_left_q != 6'd0) begin
						body_left_q <= body_dec;
						if (is_dec) begin
							neg_q <= 1'b0;
						end else if (fmt_q == itoa_pkg::FMT_HEX) begin
							sh_q <= {sh_q[27:0], 4'd0};
						end else begin
							sh_q <= {sh_q[30:0], 1'b0};
						end
					end
				end
			end
			default: ;
		endcase
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

// ===== rtl/integer_to_ascii_formatter.sv =====
// Integer to ASCII formatter. A request is taken into a short queue of QUEUE_DEPTH
// entries; the back end then emits the text one character per cycle while the
// output is not stalled. Hex gives 8 characters, binary 32, plus one for the
// terminator. Decimal first extracts the digits least significant first, each
// digit by a reciprocal multiply by one tenth, then a subtract for the remainder,
// and then emits its characters. The back end serves one item at a time with its
// single divide-by-ten unit and output port: it takes no new command from the
// queue until the last character of the current item has been emitted.
`timescale 1ns / 1ps

`include "integer_to_ascii_formatter_assert.svh"

module integer_to_ascii_formatter #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  itoa_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output itoa_pkg::rsp_t rsp
);

	itoa_pkg::cmd_t front_cmd;
	itoa_pkg::cmd_t queue_cmd;
	logic           queue_full;
	logic           queue_valid;
	logic           back_take;

	assign req_stall = queue_full;

	// front: sign and magnitude
	itoa_front u_front (
		.req (req),
		.cmd (front_cmd)
	);

	// command queue
	itoa_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (req_valid),
		.din    (front_cmd),
		.full   (queue_full),
		.pop    (back_take),
		.valid  (queue_valid),
		.dout   (queue_cmd)
	);

	// back: digit extraction and emission
	itoa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (queue_valid),
		.cmd       (queue_cmd),
		.cmd_take  (back_take),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// the longest string ends at position 32
	`ITOA_ASSERT_IMP(a_last_at_max, clk, arst_n,
		rsp_valid && (rsp.char_index == 6'd32), rsp.is_last)

	// characters of one string follow without gaps and in order
	`ITOA_ASSERT_NXT(a_next_char, clk, arst_n, rsp_valid && !rsp_stall && !rsp.is_last,
		rsp_valid && (rsp.char_index == $past(rsp.char_index) + 6'd1))

	// a new string starts at position zero
	`ITOA_ASSERT_NXT(a_new_string, clk, arst_n, rsp_valid && !rsp_stall && rsp.is_last,
		!rsp_valid || (rsp.char_index == 6'd0))

endmodule

// ===== verif/integer_to_ascii_formatter_tb.sv =====
// testbench for the integer to ascii formatter: directed and random requests checked per character
`timescale 1ns / 1ps

module integer_to_ascii_formatter_tb;

	localparam logic [6:0] CH_UPPER_A = 7'h41;
	localparam int         REPORT_LIMIT = 10;
	localparam int         RANDOM_ITEMS = 335;
	localparam int         HOLD_CYCLES = 400;
	localparam int         DRAIN_CYCLES = 60;

	typedef enum int {
		MODE_SEND_LIGHT,
		MODE_SEND_HEAVY,
		MODE_NO_IDLE
	} idle_mode_t;

	// expected text of every accepted conversion, compared character by character
	class itoa_scoreboard;
		itoa_pkg::rsp_t expected_chars[$];
		int             mismatches;

		function new();
			mismatches = 0;
		endfunction

		// work out the characters one transaction must produce
		function void note_request(itoa_pkg::req_t r);
			logic [6:0]     text[$];
			logic [6:0]     digits[$];
			logic [31:0]    mag;
			logic [3:0]     nib;
			itoa_pkg::rsp_t e;
			case (r.req_type)
				itoa_pkg::FMT_UDEC, itoa_pkg::FMT_SDEC: begin
					mag = r.value;
					if (r.req_type == itoa_pkg::FMT_SDEC && r.value[31]) begin
						text.push_back(itoa_pkg::CH_MINUS);
						mag = -r.value;
					end
					// digits come out least significant first
					do begin
						digits.push_front(itoa_pkg::CH_ZERO + 7'(mag % 10));
						mag = mag / 10;
					end while (mag != 0);
					foreach (digits[i])
						text.push_back(digits[i]);
				end
				itoa_pkg::FMT_HEX: begin
					for (int i = 7; i >= 0; i--) begin
						nib = r.value[i*4 +: 4];
						text.push_back(nib < 10 ? itoa_pkg::CH_ZERO + 7'(nib)
							: CH_UPPER_A + 7'(nib - 10));
					end
				end
				default: begin
					for (int i = 31; i >= 0; i--)
						text.push_back(itoa_pkg::CH_ZERO + 7'(r.value[i]));
				end
			endcase
			if (r.add_terminator)
				text.push_back(itoa_pkg::CH_NUL);
			foreach (text[i]) begin
				e.out_char   = text[i];
				e.char_index = 6'(i);
				e.is_last    = (i == text.size() - 1);
				expected_chars.push_back(e);
			end
		endfunction

		// compare one accepted character with the oldest expectation
		function void check_char(itoa_pkg::rsp_t got);
			itoa_pkg::rsp_t want;
			if (expected_chars.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected character: char=%h index=%0d last=%b",
						got.out_char, got.char_index, got.is_last);
				return;
			end
			want = expected_chars.pop_front();
			if (got.out_char !== want.out_char || got.char_index !== want.char_index ||
					got.is_last !== want.is_last) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("char mismatch: expected %h/%0d/%b, got %h/%0d/%b",
						want.out_char, want.char_index, want.is_last,
						got.out_char, got.char_index, got.is_last);
			end
		endfunction

		function int pending();
			return expected_chars.size();
		endfunction
	endclass

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           req_valid = 1'b0;
	logic           req_stall;
	itoa_pkg::req_t req = '0;
	logic           rsp_valid;
	logic           rsp_stall = 1'b0;
	itoa_pkg::rsp_t rsp;

	itoa_scoreboard sb = new();
	idle_mode_t     idle_mode = MODE_SEND_LIGHT;
	int             accepted_count = 0;
	int             hold_trigger = 1 << 30;
	int             hold_left = 0;
	bit             hold_done = 1'b0;

	integer_to_ascii_formatter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hard limit on the run
	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// receiver: random stalls plus one long hold-off
	always @(posedge clk) begin
		if (!hold_done && accepted_count >= hold_trigger) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			case (idle_mode)
				MODE_SEND_LIGHT: rsp_stall <= ($urandom_range(0, 99) < 59);
				MODE_SEND_HEAVY: rsp_stall <= ($urandom_range(0, 99) < 37);
				default:         rsp_stall <= 1'b0;
			endcase
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_char(rsp);
	end

	// offer one transaction, with random gaps ahead of it
	task automatic send_request(input itoa_pkg::req_t r);
		int idle_pct;
		case (idle_mode)
			MODE_SEND_LIGHT: idle_pct = 37;
			MODE_SEND_HEAVY: idle_pct = 59;
			default:         idle_pct = 0;
		endcase
		while ($urandom_range(0, 99) < idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sb.note_request(r);
		accepted_count++;
	endtask

	task automatic send_fields(input logic [31:0] value, input logic [1:0] fmt,
			input logic term);
		itoa_pkg::req_t r;
		r.value          = value;
		r.req_type       = fmt;
		r.add_terminator = term;
		send_request(r);
	endtask

	// random operand, biased toward digit-count boundaries and the sign edge
	function automatic logic [31:0] random_value();
		logic [31:0] p;
		p = 1;
		case ($urandom_range(0, 4))
			0: return $urandom_range(0, 20);
			1: begin
				repeat ($urandom_range(0, 9)) p = p * 10;
				return p + $urandom_range(0, 2) - 1;
			end
			2: return 32'h8000_0000 + $urandom_range(0, 3) - 2;
			3: return -$urandom_range(1, 20);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		itoa_pkg::req_t r;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, every format, the special cases
		send_fields(32'd0,          itoa_pkg::FMT_UDEC, 1'b0);
		send_fields(32'd0,          itoa_pkg::FMT_UDEC, 1'b1);
		send_fields(32'd9,          itoa_pkg::FMT_UDEC, 1'b0);
		send_fields(32'd10,         itoa_pkg::FMT_UDEC, 1'b1);
		send_fields(32'hFFFF_FFFF,  itoa_pkg::FMT_UDEC, 1'b0);
		send_fields(32'hFFFF_FFFF,  itoa_pkg::FMT_UDEC, 1'b1);
		send_fields(32'd0,          itoa_pkg::FMT_SDEC, 1'b0);
		send_fields(32'd0,          itoa_pkg::FMT_SDEC, 1'b1);
		send_fields(32'hFFFF_FFFF,  itoa_pkg::FMT_SDEC, 1'b0);
		send_fields(32'h8000_0000,  itoa_pkg::FMT_SDEC, 1'b0);
		send_fields(32'h8000_0000,  itoa_pkg::FMT_SDEC, 1'b1);
		send_fields(32'h7FFF_FFFF,  itoa_pkg::FMT_SDEC, 1'b1);
		send_fields(-32'sd10,       itoa_pkg::FMT_SDEC, 1'b0);
		send_fields(32'd0,          itoa_pkg::FMT_HEX,  1'b0);
		send_fields(32'hFFFF_FFFF,  itoa_pkg::FMT_HEX,  1'b1);
		send_fields(32'h0123_ABCD,  itoa_pkg::FMT_HEX,  1'b0);
		send_fields(32'h89EF_4567,  itoa_pkg::FMT_HEX,  1'b1);
		send_fields(32'd0,          itoa_pkg::FMT_BIN,  1'b0);
		send_fields(32'hFFFF_FFFF,  itoa_pkg::FMT_BIN,  1'b1);
		send_fields(32'hA5A5_A5A5,  itoa_pkg::FMT_BIN,  1'b0);

		// random: three idling phases, long receiver hold-off in the last
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 3)
				idle_mode = MODE_SEND_HEAVY;
			if (n == 2 * RANDOM_ITEMS / 3) begin
				idle_mode    = MODE_NO_IDLE;
				hold_trigger = accepted_count + 10;
			end
			r.value          = random_value();
			r.req_type       = 2'($urandom_range(0, 3));
			r.add_terminator = 1'($urandom_range(0, 1));
			send_request(r);
		end
		req_valid <= 1'b0;

		// drain
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
